### hdl/edge_move_and_partial_perm_rank_assert.svh
// Assertion macros used by the checker file.
`ifndef EDGE_MOVE_AND_PARTIAL_PERM_RANK_ASSERT_SVH
`define EDGE_MOVE_AND_PARTIAL_PERM_RANK_ASSERT_SVH

// Checked on every edge, reset included.
`define EMPR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Checked only while reset is released.
`define EMPR_ASSERT_RUN(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

### hdl/empr_pkg.sv
`default_nettype none

package empr_pkg;

  // Sizes of the cube edge problem
  localparam int SLOT_COUNT    = 12;
  localparam int TRACKED_COUNT = 6;
  localparam int MOVE_COUNT    = 18;

  localparam int TABLE_MOVES = 18;
  localparam int TABLE_SLOTS = 12;

  localparam int SLOT_W   = 4;
  localparam int MOVE_W   = 5;
  localparam int RANK_W   = 20;
  // internal rank width, wide enough for the unmasked sum
  localparam int CALC_W   = 24;
  localparam int DIGIT_W  = 4;
  localparam int USED_W   = 16;

  // Moves and slots that the table really covers
  localparam int MOVE_LIMIT = (MOVE_COUNT < TABLE_MOVES) ? MOVE_COUNT : TABLE_MOVES;
  localparam int SLOT_LIMIT = (SLOT_COUNT < TABLE_SLOTS) ? SLOT_COUNT : TABLE_SLOTS;

  // Pipeline depth from accepted item to result strobe
  localparam int PIPE_LAT = 5;

  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [MOVE_W-1:0]  move_t;
  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [CALC_W-1:0]  calc_t;
  typedef calc_t weight_arr_t [TRACKED_COUNT];

  // Target slot for each move and slot; untouched slots map to themselves
  localparam slot_t MOVE_MAP [TABLE_MOVES][TABLE_SLOTS] = '{
    '{ 2, 0, 3, 1, 4, 5, 6, 7, 8, 9,10,11},
    '{ 1, 3, 0, 2, 4, 5, 6, 7, 8, 9,10,11},
    '{ 0, 1, 2, 3, 4, 5, 6, 7, 9,11, 8,10},
    '{ 0, 1, 2, 3, 4, 5, 6, 7,10, 8,11, 9},
    '{ 4, 1, 2, 3, 8, 0, 6, 7, 5, 9,10,11},
    '{ 5, 1, 2, 3, 0, 8, 6, 7, 4, 9,10,11},
    '{ 0, 1, 2, 7, 4, 5, 3,11, 8, 9,10, 6},
    '{ 0, 1, 2, 6, 4, 5,11, 3, 8, 9,10, 7},
    '{ 0, 6, 2, 3, 1, 5, 9, 7, 8, 4,10,11},
    '{ 0, 4, 2, 3, 9, 5, 1, 7, 8, 6,10,11},
    '{ 0, 1, 5, 3, 4,10, 6, 2, 8, 9, 7,11},
    '{ 0, 1, 7, 3, 4, 2, 6,10, 8, 9, 5,11},
    '{ 2, 0, 3, 1, 4, 5, 6, 7,10, 8,11, 9},
    '{ 1, 3, 0, 2, 4, 5, 6, 7, 9,11, 8,10},
    '{ 4, 1, 2, 6, 8, 0,11, 3, 5, 9,10, 7},
    '{ 5, 1, 2, 7, 0, 8, 3,11, 4, 9,10, 6},
    '{ 0, 4, 5, 3, 9,10, 1, 2, 8, 6, 7,11},
    '{ 0, 6, 7, 3, 1, 2, 9,10, 8, 4, 5,11}
  };

  // Radix of digit i
  function automatic int radix_at(int i);
    int r;
    r = (i < SLOT_COUNT) ? (SLOT_COUNT - i) : 1;
    return r;
  endfunction

  // Place value of each digit: product of the radices after it
  function automatic weight_arr_t rank_weights();
    weight_arr_t w;
    int acc;
    acc = 1;
    for (int i = TRACKED_COUNT - 1; i >= 0; i--) begin
      w[i] = CALC_W'(acc);
      acc  = acc * radix_at(i);
    end
    return w;
  endfunction

  // Number of distinct partial permutations
  function automatic int rank_bound();
    int b;
    b = 1;
    for (int i = 0; i < TRACKED_COUNT; i++) begin
      b = b * radix_at(i);
    end
    return b;
  endfunction

  localparam weight_arr_t RANK_WEIGHT = rank_weights();
  localparam calc_t       RANK_BOUND  = CALC_W'(rank_bound());

  // Slot after the move; unknown moves and out-of-range slots pass through
  function automatic slot_t move_slot(move_t mv, slot_t s);
    slot_t r;
    r = s;
    if (({1'b0, mv} < 6'(MOVE_LIMIT)) && (s < SLOT_W'(SLOT_LIMIT))) begin
      r = MOVE_MAP[mv][s];
    end
    return r;
  endfunction

  // Free slots below s, given the set already taken
  function automatic digit_t free_below(slot_t s, logic [USED_W-1:0] used);
    digit_t cnt;
    cnt = '0;
    for (int j = 0; j < USED_W; j++) begin
      if ((SLOT_W'(j) < s) && !used[j]) begin
        cnt = cnt + 1'b1;
      end
    end
    return cnt;
  endfunction

endpackage

`default_nettype wire

### hdl/edge_move_and_partial_perm_rank.sv
// Channel  | Ports                                         | Handshake
// ---------+-----------------------------------------------+----------------------------
// input    | in_piece_pos_0..5, in_move_code               | taken when start && !busy
// result   | out_old_rank(_bad), out_new_rank(_bad),       | out_valid, one cycle,
//          | out_moved_pos_0..5                            | no back-pressure
//
// One item per clock; each result passes through the stages below in order.
// Stages: input register, move table lookup, digit count, partial sums, final sum.
// busy is high only while rst_n is low; reset is synchronous and clears the valid bits.
// Nothing stalls: the result strobe cannot be held off, so the pipe always advances.
`default_nettype none

module edge_move_and_partial_perm_rank
  import empr_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [SLOT_W-1:0]   in_piece_pos_0,
  input  wire logic [SLOT_W-1:0]   in_piece_pos_1,
  input  wire logic [SLOT_W-1:0]   in_piece_pos_2,
  input  wire logic [SLOT_W-1:0]   in_piece_pos_3,
  input  wire logic [SLOT_W-1:0]   in_piece_pos_4,
  input  wire logic [SLOT_W-1:0]   in_piece_pos_5,
  input  wire logic [MOVE_W-1:0]   in_move_code,
  output logic                     out_valid,
  output logic [RANK_W-1:0]        out_old_rank,
  output logic                     out_old_rank_bad,
  output logic [RANK_W-1:0]        out_new_rank,
  output logic                     out_new_rank_bad,
  output logic [SLOT_W-1:0]        out_moved_pos_0,
  output logic [SLOT_W-1:0]        out_moved_pos_1,
  output logic [SLOT_W-1:0]        out_moved_pos_2,
  output logic [SLOT_W-1:0]        out_moved_pos_3,
  output logic [SLOT_W-1:0]        out_moved_pos_4,
  output logic [SLOT_W-1:0]        out_moved_pos_5
);

  localparam int HALF = TRACKED_COUNT / 2;

  logic accept;

  // stage 1: input register
  logic  s1_valid_r;
  slot_t s1_pos_r [TRACKED_COUNT];
  move_t s1_move_r;
  slot_t in_pos   [TRACKED_COUNT];

  // stage 2: slots before and after the move
  logic  s2_valid_r;
  slot_t s2_old_r [TRACKED_COUNT];
  slot_t s2_new_r [TRACKED_COUNT];
  slot_t s2_new_nxt [TRACKED_COUNT];

  // stage 3: digits
  logic   s3_valid_r;
  digit_t s3_old_dig_r [TRACKED_COUNT];
  digit_t s3_new_dig_r [TRACKED_COUNT];
  slot_t  s3_new_r     [TRACKED_COUNT];
  digit_t s3_old_dig_nxt [TRACKED_COUNT];
  digit_t s3_new_dig_nxt [TRACKED_COUNT];

  // stage 4: two partial sums per rank
  logic  s4_valid_r;
  calc_t s4_old_lo_r, s4_old_hi_r, s4_new_lo_r, s4_new_hi_r;
  calc_t s4_old_lo_nxt, s4_old_hi_nxt, s4_new_lo_nxt, s4_new_hi_nxt;
  slot_t s4_new_r [TRACKED_COUNT];

  // stage 5: result register
  logic  out_valid_r;
  calc_t old_sum_nxt, new_sum_nxt;
  logic [RANK_W-1:0] old_rank_r, new_rank_r;
  logic  old_bad_r, new_bad_r;
  slot_t out_pos_r [TRACKED_COUNT];

  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  assign in_pos[0] = in_piece_pos_0;
  assign in_pos[1] = in_piece_pos_1;
  assign in_pos[2] = in_piece_pos_2;
  assign in_pos[3] = in_piece_pos_3;
  assign in_pos[4] = in_piece_pos_4;
  assign in_pos[5] = in_piece_pos_5;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= accept;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      out_valid_r <= s4_valid_r;
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    s1_move_r <= in_move_code;
    for (int i = 0; i < TRACKED_COUNT; i++) begin
      s1_pos_r[i] <= in_pos[i];
    end
  end

  // stage 2: table lookup per piece
  always_comb begin
    for (int i = 0; i < TRACKED_COUNT; i++) begin
      s2_new_nxt[i] = move_slot(s1_move_r, s1_pos_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < TRACKED_COUNT; i++) begin
      s2_old_r[i] <= s1_pos_r[i];
      s2_new_r[i] <= s2_new_nxt[i];
    end
  end

  // stage 3: each digit counts free slots below its slot
  always_comb begin
    logic [USED_W-1:0] old_used;
    logic [USED_W-1:0] new_used;
    old_used = '0;
    new_used = '0;
    for (int i = 0; i < TRACKED_COUNT; i++) begin
      s3_old_dig_nxt[i] = free_below(s2_old_r[i], old_used);
      s3_new_dig_nxt[i] = free_below(s2_new_r[i], new_used);
      old_used[s2_old_r[i]] = 1'b1;
      new_used[s2_new_r[i]] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < TRACKED_COUNT; i++) begin
      s3_old_dig_r[i] <= s3_old_dig_nxt[i];
      s3_new_dig_r[i] <= s3_new_dig_nxt[i];
      s3_new_r[i]     <= s2_new_r[i];
    end
  end

  // stage 4: digit times place value, summed in two halves
  always_comb begin
    s4_old_lo_nxt = '0;
    s4_old_hi_nxt = '0;
    s4_new_lo_nxt = '0;
    s4_new_hi_nxt = '0;
    for (int i = 0; i < TRACKED_COUNT; i++) begin
      if (i < HALF) begin
        s4_old_hi_nxt = s4_old_hi_nxt + CALC_W'(s3_old_dig_r[i]) * RANK_WEIGHT[i];
        s4_new_hi_nxt = s4_new_hi_nxt + CALC_W'(s3_new_dig_r[i]) * RANK_WEIGHT[i];
      end else begin
        s4_old_lo_nxt = s4_old_lo_nxt + CALC_W'(s3_old_dig_r[i]) * RANK_WEIGHT[i];
        s4_new_lo_nxt = s4_new_lo_nxt + CALC_W'(s3_new_dig_r[i]) * RANK_WEIGHT[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    s4_old_lo_r <= s4_old_lo_nxt;
    s4_old_hi_r <= s4_old_hi_nxt;
    s4_new_lo_r <= s4_new_lo_nxt;
    s4_new_hi_r <= s4_new_hi_nxt;
    for (int i = 0; i < TRACKED_COUNT; i++) begin
      s4_new_r[i] <= s3_new_r[i];
    end
  end

  // stage 5: final add, bound check on the unmasked sum
  assign old_sum_nxt = s4_old_hi_r + s4_old_lo_r;
  assign new_sum_nxt = s4_new_hi_r + s4_new_lo_r;

  always_ff @(posedge clk) begin
    old_rank_r <= old_sum_nxt[RANK_W-1:0];
    new_rank_r <= new_sum_nxt[RANK_W-1:0];
    old_bad_r  <= (old_sum_nxt >= RANK_BOUND);
    new_bad_r  <= (new_sum_nxt >= RANK_BOUND);
    for (int i = 0; i < TRACKED_COUNT; i++) begin
      out_pos_r[i] <= s4_new_r[i];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_old_rank     = old_rank_r;
  assign out_old_rank_bad = old_bad_r;
  assign out_new_rank     = new_rank_r;
  assign out_new_rank_bad = new_bad_r;
  assign out_moved_pos_0  = out_pos_r[0];
  assign out_moved_pos_1  = out_pos_r[1];
  assign out_moved_pos_2  = out_pos_r[2];
  assign out_moved_pos_3  = out_pos_r[3];
  assign out_moved_pos_4  = out_pos_r[4];
  assign out_moved_pos_5  = out_pos_r[5];

endmodule

`default_nettype wire

### hdl/empr_checker.sv
`default_nettype none
`include "edge_move_and_partial_perm_rank_assert.svh"

module empr_checker
  import empr_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                start,
  input wire logic                busy,
  input wire logic [SLOT_W-1:0]   in_piece_pos_0,
  input wire logic [MOVE_W-1:0]   in_move_code,
  input wire logic                out_valid,
  input wire logic [RANK_W-1:0]   out_old_rank,
  input wire logic                out_old_rank_bad,
  input wire logic [RANK_W-1:0]   out_new_rank,
  input wire logic                out_new_rank_bad,
  input wire logic [SLOT_W-1:0]   out_moved_pos_0
);

  // busy only covers reset
  `EMPR_ASSERT_ALWAYS(a_busy_reset, clk, busy == !rst_n, "busy outside reset")

  // every strobe traces back to an item taken at the pipe depth
  `EMPR_ASSERT_RUN(a_no_spurious, clk, rst_n, out_valid |-> $past(start && !busy, PIPE_LAT), "result without item")

  // an item taken with reset held off since then gives a result
  `EMPR_ASSERT_RUN(a_no_loss, clk, rst_n, ($past(start && !busy, PIPE_LAT) && $past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3) && $past(rst_n, 4)) |-> out_valid, "item lost")

  // flags agree with the ranks shown
  `EMPR_ASSERT_RUN(a_bad_flags, clk, rst_n, out_valid |-> ((out_old_rank_bad == (CALC_W'(out_old_rank) >= RANK_BOUND)) && (out_new_rank_bad == (CALC_W'(out_new_rank) >= RANK_BOUND))), "rank flag mismatch")

  // an unknown move leaves the slot where it was
  `EMPR_ASSERT_RUN(a_unknown_move, clk, rst_n, (out_valid && ({1'b0, $past(in_move_code, PIPE_LAT)} >= 6'(MOVE_LIMIT))) |-> (out_moved_pos_0 == $past(in_piece_pos_0, PIPE_LAT)), "unknown move changed a slot")

endmodule

bind edge_move_and_partial_perm_rank empr_checker u_empr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_piece_pos_0   (in_piece_pos_0),
  .in_move_code     (in_move_code),
  .out_valid        (out_valid),
  .out_old_rank     (out_old_rank),
  .out_old_rank_bad (out_old_rank_bad),
  .out_new_rank     (out_new_rank),
  .out_new_rank_bad (out_new_rank_bad),
  .out_moved_pos_0  (out_moved_pos_0)
);

`default_nettype wire

### sim/edge_move_and_partial_perm_rank_test.sv
`timescale 1ns / 1ps

import empr_pkg::*;

// One input item: six tracked slots and a move
typedef struct packed {
  slot_t [TRACKED_COUNT-1:0] pos;
  move_t                     move;
} edge_item_t;

// One result item, laid out in port order
typedef struct packed {
  logic [RANK_W-1:0]         old_rank;
  logic                      old_bad;
  logic [RANK_W-1:0]         new_rank;
  logic                      new_bad;
  slot_t [TRACKED_COUNT-1:0] moved;
} rank_result_t;

// Move codes, in table order
typedef enum logic [MOVE_W-1:0] {
  MV_R, MV_RI, MV_L, MV_LI, MV_U, MV_UI, MV_D, MV_DI, MV_F, MV_FI,
  MV_B, MV_BI, MV_M, MV_MI, MV_E, MV_EI, MV_S, MV_SI,
  MV_FIRST_UNKNOWN,
  MV_ALL_ONES = 5'h1f
} cube_move_e;

// Predicts move-and-rank results and checks them in order
class edge_rank_ledger;
  rank_result_t pending_ranks[$];
  slot_t        turn_map [18][12];
  longint       perm_count;
  int           mismatches;
  int           items_noted;
  int           results_seen;
  int           flagged_seen;

  function new();
    turn_map = '{
      '{ 2, 0, 3, 1, 4, 5, 6, 7, 8, 9,10,11},
      '{ 1, 3, 0, 2, 4, 5, 6, 7, 8, 9,10,11},
      '{ 0, 1, 2, 3, 4, 5, 6, 7, 9,11, 8,10},
      '{ 0, 1, 2, 3, 4, 5, 6, 7,10, 8,11, 9},
      '{ 4, 1, 2, 3, 8, 0, 6, 7, 5, 9,10,11},
      '{ 5, 1, 2, 3, 0, 8, 6, 7, 4, 9,10,11},
      '{ 0, 1, 2, 7, 4, 5, 3,11, 8, 9,10, 6},
      '{ 0, 1, 2, 6, 4, 5,11, 3, 8, 9,10, 7},
      '{ 0, 6, 2, 3, 1, 5, 9, 7, 8, 4,10,11},
      '{ 0, 4, 2, 3, 9, 5, 1, 7, 8, 6,10,11},
      '{ 0, 1, 5, 3, 4,10, 6, 2, 8, 9, 7,11},
      '{ 0, 1, 7, 3, 4, 2, 6,10, 8, 9, 5,11},
      '{ 2, 0, 3, 1, 4, 5, 6, 7,10, 8,11, 9},
      '{ 1, 3, 0, 2, 4, 5, 6, 7, 9,11, 8,10},
      '{ 4, 1, 2, 6, 8, 0,11, 3, 5, 9,10, 7},
      '{ 5, 1, 2, 7, 0, 8, 3,11, 4, 9,10, 6},
      '{ 0, 4, 5, 3, 9,10, 1, 2, 8, 6, 7,11},
      '{ 0, 6, 7, 3, 1, 2, 9,10, 8, 4, 5,11}
    };
    perm_count = 1;
    for (int i = 0; i < TRACKED_COUNT; i++) begin
      perm_count = perm_count * place_radix(i);
    end
  endfunction

  function int place_radix(int i);
    return (i < SLOT_COUNT) ? (SLOT_COUNT - i) : 1;
  endfunction

  // Mixed-radix rank: each digit counts free slots below the current one
  function longint lehmer_rank(slot_t [TRACKED_COUNT-1:0] s);
    logic [15:0] taken;
    longint      r;
    int          d;
    taken = '0;
    r = 0;
    for (int i = 0; i < TRACKED_COUNT; i++) begin
      d = 0;
      for (int j = 0; j < 16; j++) begin
        if (j < s[i] && !taken[j]) d++;
      end
      taken[s[i]] = 1'b1;
      r = r * place_radix(i) + d;
    end
    return r;
  endfunction

  function rank_result_t predict_move_rank(edge_item_t it);
    rank_result_t res;
    longint       r_old;
    longint       r_new;
    bit           move_known;
    move_known = (it.move < MOVE_COUNT) && (it.move < 18);
    for (int i = 0; i < TRACKED_COUNT; i++) begin
      // unknown moves and off-table slots pass through
      if (move_known && it.pos[i] < 12 && it.pos[i] < SLOT_COUNT)
        res.moved[i] = turn_map[it.move][it.pos[i]];
      else
        res.moved[i] = it.pos[i];
    end
    r_old = lehmer_rank(it.pos);
    r_new = lehmer_rank(res.moved);
    res.old_rank = r_old[RANK_W-1:0];
    res.old_bad  = (r_old >= perm_count);
    res.new_rank = r_new[RANK_W-1:0];
    res.new_bad  = (r_new >= perm_count);
    return res;
  endfunction

  function void note_item(edge_item_t it);
    pending_ranks.push_back(predict_move_rank(it));
    items_noted++;
  endfunction

  function void check_result(rank_result_t got);
    rank_result_t want;
    if (pending_ranks.size() == 0) begin
      $error("result with nothing pending: old_rank %0d new_rank %0d",
             got.old_rank, got.new_rank);
      mismatches++;
      return;
    end
    want = pending_ranks.pop_front();
    results_seen++;
    if (want.old_bad || want.new_bad) flagged_seen++;
    if (got.old_rank !== want.old_rank) begin
      $error("old_rank: expected %0d, got %0d", want.old_rank, got.old_rank);
      mismatches++;
    end
    if (got.old_bad !== want.old_bad) begin
      $error("old_rank_bad: expected %0b, got %0b", want.old_bad, got.old_bad);
      mismatches++;
    end
    if (got.new_rank !== want.new_rank) begin
      $error("new_rank: expected %0d, got %0d", want.new_rank, got.new_rank);
      mismatches++;
    end
    if (got.new_bad !== want.new_bad) begin
      $error("new_rank_bad: expected %0b, got %0b", want.new_bad, got.new_bad);
      mismatches++;
    end
    for (int i = 0; i < TRACKED_COUNT; i++) begin
      if (got.moved[i] !== want.moved[i]) begin
        $error("moved_pos_%0d: expected %0d, got %0d", i, want.moved[i], got.moved[i]);
        mismatches++;
      end
    end
  endfunction
endclass

module edge_move_and_partial_perm_rank_test;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int ITEMS_PHASE  = 450;
  localparam int SETTLE_TICKS = 4 * PIPE_LAT;

  logic         clk = 1'b0;
  logic         rst_n;
  logic         start;
  logic         busy;
  edge_item_t   stim;
  logic         out_valid;
  logic [RANK_W-1:0] out_old_rank;
  logic         out_old_rank_bad;
  logic [RANK_W-1:0] out_new_rank;
  logic         out_new_rank_bad;
  slot_t        out_moved_pos_0, out_moved_pos_1, out_moved_pos_2;
  slot_t        out_moved_pos_3, out_moved_pos_4, out_moved_pos_5;
  rank_result_t seen_result;
  int           cycle_count = 0;

  edge_rank_ledger ledger = new();

  always #1 clk = ~clk;

  edge_move_and_partial_perm_rank uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_piece_pos_0   (stim.pos[0]),
    .in_piece_pos_1   (stim.pos[1]),
    .in_piece_pos_2   (stim.pos[2]),
    .in_piece_pos_3   (stim.pos[3]),
    .in_piece_pos_4   (stim.pos[4]),
    .in_piece_pos_5   (stim.pos[5]),
    .in_move_code     (stim.move),
    .out_valid        (out_valid),
    .out_old_rank     (out_old_rank),
    .out_old_rank_bad (out_old_rank_bad),
    .out_new_rank     (out_new_rank),
    .out_new_rank_bad (out_new_rank_bad),
    .out_moved_pos_0  (out_moved_pos_0),
    .out_moved_pos_1  (out_moved_pos_1),
    .out_moved_pos_2  (out_moved_pos_2),
    .out_moved_pos_3  (out_moved_pos_3),
    .out_moved_pos_4  (out_moved_pos_4),
    .out_moved_pos_5  (out_moved_pos_5)
  );

  assign seen_result = {out_old_rank, out_old_rank_bad, out_new_rank, out_new_rank_bad,
                        out_moved_pos_5, out_moved_pos_4, out_moved_pos_3,
                        out_moved_pos_2, out_moved_pos_1, out_moved_pos_0};

  // Accept items and results on the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) ledger.note_item(stim);
      if (out_valid) ledger.check_result(seen_result);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic edge_item_t make_item(int p0, int p1, int p2, int p3, int p4,
                                           int p5, int mv);
    edge_item_t it;
    it.pos[0] = slot_t'(p0);
    it.pos[1] = slot_t'(p1);
    it.pos[2] = slot_t'(p2);
    it.pos[3] = slot_t'(p3);
    it.pos[4] = slot_t'(p4);
    it.pos[5] = slot_t'(p5);
    it.move   = move_t'(mv);
    return it;
  endfunction

  // Six distinct slots drawn from a shuffled deck of twelve
  function automatic edge_item_t distinct_slots();
    edge_item_t it;
    int         deck[12];
    int         k;
    int         tmp;
    for (int i = 0; i < 12; i++) deck[i] = i;
    for (int i = 11; i > 0; i--) begin
      k = $urandom_range(i);
      tmp = deck[i];
      deck[i] = deck[k];
      deck[k] = tmp;
    end
    for (int i = 0; i < TRACKED_COUNT; i++) it.pos[i] = slot_t'(deck[i]);
    it.move = move_t'($urandom_range(MOVE_COUNT - 1));
    return it;
  endfunction

  // Mostly legal tuples; some repeats, junk slots and unknown moves
  function automatic edge_item_t random_item();
    edge_item_t it;
    int         kind;
    int         a;
    int         b;
    kind = $urandom_range(99);
    it = distinct_slots();
    if (kind >= 70 && kind < 80) begin
      a = $urandom_range(TRACKED_COUNT - 1);
      b = $urandom_range(TRACKED_COUNT - 1);
      it.pos[b] = it.pos[a];
    end else if (kind >= 80 && kind < 90) begin
      for (int i = 0; i < TRACKED_COUNT; i++) it.pos[i] = slot_t'($urandom_range(15));
      it.move = move_t'($urandom_range(31));
    end else if (kind >= 90) begin
      it.move = move_t'($urandom_range(31, MV_FIRST_UNKNOWN));
    end
    return it;
  endfunction

  task automatic send_item(edge_item_t it);
    @(negedge clk);
    stim  = it;
    start = 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // Random gap after an item; fields carry noise while start is low
  task automatic sender_gap(int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
      stim  = edge_item_t'({$urandom, $urandom});
      @(posedge clk);
    end
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    start = 1'b0;
    while (ledger.pending_ranks.size() != 0) @(posedge clk);
  endtask

  initial begin
    edge_item_t directed[$];
    int         phase_idle[4];

    rst_n = 1'b0;
    start = 1'b0;
    stim  = '0;
    phase_idle = '{0, 79, 10, 0};
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Directed: every move on distinct slots, then the corner tuples
    for (int m = MV_R; m <= MV_SI; m++) begin
      directed.push_back(make_item(m % 12, (m + 1) % 12, (m + 2) % 12, (m + 3) % 12,
                                   (m + 4) % 12, (m + 5) % 12, m));
    end
    directed.push_back(make_item(11, 10, 9, 8, 7, 6, MV_U));
    directed.push_back(make_item(0, 0, 0, 0, 0, 0, MV_R));
    directed.push_back(make_item(11, 11, 11, 11, 11, 11, MV_SI));
    directed.push_back(make_item(15, 15, 15, 15, 15, 15, MV_ALL_ONES));
    directed.push_back(make_item(12, 13, 14, 15, 0, 11, MV_FIRST_UNKNOWN));
    directed.push_back(make_item(4, 8, 0, 5, 12, 3, MV_E));
    foreach (directed[i]) send_item(directed[i]);
    hold_until_drained();

    // Random phases, each with its own sender gap, draining after each phase
    foreach (phase_idle[p]) begin
      for (int n = 0; n < ITEMS_PHASE; n++) begin
        send_item(random_item());
        sender_gap(phase_idle[p]);
      end
      hold_until_drained();
    end

    repeat (SETTLE_TICKS) @(posedge clk);
    if (ledger.pending_ranks.size() != 0) begin
      $error("%0d expected results never arrived", ledger.pending_ranks.size());
      ledger.mismatches++;
    end
    $display("Moved and ranked %0d edge tuples over all 18 turns plus unknown codes;",
             ledger.items_noted);
    $display("%0d results checked, %0d of them with a rank flag raised.",
             ledger.results_seen, ledger.flagged_seen);
    if (ledger.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/empr_pkg.sv
hdl/edge_move_and_partial_perm_rank.sv
hdl/empr_checker.sv
sim/edge_move_and_partial_perm_rank_test.sv
